FILE: design/btlv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlv_pkg
// Shared types and constants of the BER TLV stream decoder: tag codes, event
// kinds, the event record and the control bundles between the submodules.
// ----------------------------------------------------------------------------
package btlv_pkg;

  // Universal / context tags handled by the decoder
  localparam logic [7:0] TAG_INT  = 8'h02;
  localparam logic [7:0] TAG_STR  = 8'h04;
  localparam logic [7:0] TAG_NULL = 8'h05;
  localparam logic [7:0] TAG_OID  = 8'h06;
  localparam logic [7:0] TAG_SEQ  = 8'h30;
  localparam logic [7:0] TAG_GET  = 8'hA0;

  // Error codes carried in the value field of an error event
  localparam logic [31:0] ERR_OVERRUN  = 32'd0;
  localparam logic [31:0] ERR_TOO_DEEP = 32'd1;

  // Depth of the result queue (must leave room for a two-event byte)
  localparam int EVQ_DEPTH = 4;

  typedef enum logic [3:0] {
    EV_INT  = 4'd0,
    EV_STR  = 4'd1,
    EV_BYTE = 4'd2,
    EV_NULL = 4'd3,
    EV_ARC  = 4'd4,
    EV_SEQ  = 4'd5,
    EV_GET  = 4'd6,
    EV_UNK  = 4'd7,
    EV_ERR  = 4'd8
  } evt_kind_t;

  // One result item
  typedef struct packed {
    evt_kind_t   kind;
    logic [3:0]  level;
    logic [31:0] value;
    logic        last;
  } evt_t;

  // Up to two events written to the result queue per decoded byte
  typedef struct packed {
    logic [1:0] cnt;
    evt_t       ev0;
    evt_t       ev1;
  } evq_wr_t;

  // Commands to the container level stack
  typedef struct packed {
    logic       consume;   // one byte read inside all open containers
    logic       push;      // open a new container
    logic [7:0] push_val;  // its length
    logic       close;     // pop containers that ran out
    logic       clear;     // end of message
  } lvl_ctl_t;

endpackage

FILE: design/btlv_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlv_if
// Valid/ready channels of the decoder: message bytes in, decode events out.
// ----------------------------------------------------------------------------
interface btlv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_message;

  modport source (output valid, output in_byte, output end_of_message, input ready);
  modport sink   (input valid, input in_byte, input end_of_message, output ready);
endinterface

interface btlv_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [3:0]  nest_level;
  logic [31:0] event_value;
  logic        last_of_run;

  modport source (output valid, output event_kind, output nest_level,
                  output event_value, output last_of_run, input ready);
  modport sink   (input valid, input event_kind, input nest_level,
                  input event_value, input last_of_run, output ready);
endinterface

FILE: design/ber_tlv_stream_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_tlv_stream_decoder
// Streams message bytes through a short-form BER TLV walker and reports
// integers, strings, OID arcs, containers, unknown tags and errors.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload                                         Transfer
//  in_ch    in   in_byte[7:0], end_of_message                    valid & ready
//  out_ch   out  event_kind[3:0], nest_level[3:0],
//                event_value[31:0], last_of_run                  valid & ready
//
//  One byte per cycle sustained while the result queue has room; a byte is
//  registered on transfer, decoded from that register, and its events queued.
//  The first OID subidentifier makes two events and takes two output
//  transfers; the output port sets the rate then.
//  rst_n is synchronous; no clearing pass. in_ch stalls when the 4-entry
//  result queue has fewer than two free entries.
// ----------------------------------------------------------------------------
module ber_tlv_stream_decoder #(
  parameter int MAX_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  btlv_in_if.sink      in_ch,
  btlv_out_if.source   out_ch
);

  localparam int DW = $clog2(MAX_DEPTH + 1);

  btlv_pkg::lvl_ctl_t lvl_ctl;
  btlv_pkg::evq_wr_t  evq_wr;
  logic               room;
  logic [DW-1:0]      depth;
  logic [7:0]         top_rem;

  // Byte decode
  btlv_parser #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .room_i    (room),
    .depth_i   (depth),
    .top_rem_i (top_rem),
    .lvl_ctl_o (lvl_ctl),
    .evq_wr_o  (evq_wr)
  );

  // Open container counters
  btlv_level_stack #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_level_stack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl_i     (lvl_ctl),
    .depth_o   (depth),
    .top_rem_o (top_rem)
  );

  // Result queue
  btlv_evt_queue u_evt_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_i   (evq_wr),
    .room_o (room),
    .out_ch (out_ch)
  );

endmodule

FILE: design/btlv_level_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlv_level_stack
// Byte counters of the open containers. All open levels count down together;
// a level pushed by a child never exceeds its parent, so the open levels stay
// ordered and a close is a count of the levels that are still nonzero.
// ----------------------------------------------------------------------------
module btlv_level_stack #(
  parameter int MAX_DEPTH = 8,
  localparam int DW = $clog2(MAX_DEPTH + 1),
  localparam int IW = $clog2(MAX_DEPTH)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  btlv_pkg::lvl_ctl_t  ctl_i,
  output logic [DW-1:0]       depth_o,
  output logic [7:0]          top_rem_o
);

  logic [7:0]    rem_r   [MAX_DEPTH];
  logic [7:0]    rem_nxt [MAX_DEPTH];
  logic [DW-1:0] depth_r;
  logic [DW-1:0] depth_nxt;
  logic [DW-1:0] depth_push;
  logic [DW-1:0] nz_cnt;
  logic [IW-1:0] top_idx;

  // Count down, push, then close exhausted levels
  always_comb begin
    depth_push = depth_r + DW'(ctl_i.push);
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (ctl_i.consume && (DW'(i) < depth_r) && (rem_r[i] != 8'd0)) begin
        rem_nxt[i] = rem_r[i] - 8'd1;
      end else begin
        rem_nxt[i] = rem_r[i];
      end
    end
    if (ctl_i.push) begin
      rem_nxt[depth_r[IW-1:0]] = ctl_i.push_val;
    end
    nz_cnt = '0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if ((DW'(i) < depth_push) && (rem_nxt[i] != 8'd0)) begin
        nz_cnt = nz_cnt + DW'(1);
      end
    end
    priority if (ctl_i.clear) begin
      depth_nxt = '0;
    end else if (ctl_i.close) begin
      depth_nxt = nz_cnt;
    end else begin
      depth_nxt = depth_push;
    end
  end

  // Counters hold no reset: a level is always written when it opens
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      rem_r[i] <= rem_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= '0;
    end else begin
      depth_r <= depth_nxt;
    end
  end

  // Innermost open level; meaningful only while depth is nonzero
  assign top_idx   = IW'(depth_r - DW'(1));
  assign top_rem_o = rem_r[top_idx];
  assign depth_o   = depth_r;

endmodule

FILE: design/btlv_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlv_parser
// Input register and the per-byte decode: tag / length / content phases,
// integer and OID accumulation, and event generation into the result queue.
// ----------------------------------------------------------------------------
module btlv_parser #(
  parameter int MAX_DEPTH = 8,
  localparam int DW = $clog2(MAX_DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  btlv_in_if.sink             in_ch,
  input  logic                room_i,
  input  logic [DW-1:0]       depth_i,
  input  logic [7:0]          top_rem_i,
  output btlv_pkg::lvl_ctl_t  lvl_ctl_o,
  output btlv_pkg::evq_wr_t   evq_wr_o
);

  typedef enum logic [3:0] {
    PH_TAG     = 4'b0001,
    PH_LEN     = 4'b0010,
    PH_CONTENT = 4'b0100,
    PH_DISCARD = 4'b1000
  } phase_t;

  // Quotient by 40 through a reciprocal multiply: (x >> 3) / 5
  function automatic logic [26:0] div40(input logic [31:0] x);
    logic [60:0] prod;
    prod = 61'(x[31:3]) * 61'(32'hCCCC_CCCD);
    return prod[60:34];
  endfunction

  // Input register
  logic       in_v_r;
  logic [7:0] byte_r;
  logic       eom_r;
  logic       fire;

  // Decoder state
  phase_t      phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [7:0]  elem_r, elem_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic        fsp_r, fsp_nxt;

  // Per-byte working values
  logic                  nested;
  logic [7:0]            top_after;
  logic [7:0]            elem_dec;
  logic [31:0]           acc_int;
  logic [31:0]           acc_oid;
  logic [26:0]           oid_q;
  logic [31:0]           oid_r_full;
  logic [1:0]            ev_cnt;
  btlv_pkg::evt_kind_t   ev0_kind, ev1_kind;
  logic [31:0]           ev0_val, ev1_val;
  logic                  consume, push;
  logic [3:0]            lvl;

  // Handshake: decode fires when the queue can take two events
  assign fire         = in_v_r && room_i;
  assign in_ch.ready  = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.in_byte;
      eom_r  <= in_ch.end_of_message;
    end
  end

  // Arithmetic helpers
  assign nested     = (depth_i != '0);
  assign top_after  = (top_rem_i != 8'd0) ? top_rem_i - 8'd1 : 8'd0;
  assign elem_dec   = (elem_r != 8'd0) ? elem_r - 8'd1 : 8'd0;
  assign acc_int    = {acc_r[23:0], byte_r};
  assign acc_oid    = {acc_r[24:0], byte_r[6:0]};
  assign oid_q      = div40(acc_oid);
  assign oid_r_full = acc_oid - ({oid_q, 5'b0} + {2'b0, oid_q, 3'b0});
  assign lvl        = 4'(depth_i);

  // Phase decode and event selection
  always_comb begin
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    elem_nxt  = elem_r;
    acc_nxt   = acc_r;
    fsp_nxt   = fsp_r;
    ev_cnt    = 2'd0;
    ev0_kind  = btlv_pkg::EV_INT;
    ev0_val   = '0;
    ev1_kind  = btlv_pkg::EV_ARC;
    ev1_val   = '0;
    consume   = 1'b0;
    push      = 1'b0;
    unique case (phase_r)
      PH_TAG: begin
        if (nested && (top_rem_i <= 8'd1)) begin
          // header cannot fit in the parent
          phase_nxt = PH_DISCARD;
          ev_cnt    = 2'd1;
          ev0_kind  = btlv_pkg::EV_ERR;
          ev0_val   = btlv_pkg::ERR_OVERRUN;
        end else begin
          consume   = 1'b1;
          tag_nxt   = byte_r;
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        consume = 1'b1;
        if (nested && (byte_r > top_after)) begin
          phase_nxt = PH_DISCARD;
          ev_cnt    = 2'd1;
          ev0_kind  = btlv_pkg::EV_ERR;
          ev0_val   = btlv_pkg::ERR_OVERRUN;
        end else begin
          elem_nxt  = byte_r;
          acc_nxt   = '0;
          phase_nxt = (byte_r == 8'd0) ? PH_TAG : PH_CONTENT;
          unique case (tag_r)
            btlv_pkg::TAG_SEQ, btlv_pkg::TAG_GET: begin
              if (depth_i >= DW'(MAX_DEPTH)) begin
                phase_nxt = PH_DISCARD;
                ev_cnt    = 2'd1;
                ev0_kind  = btlv_pkg::EV_ERR;
                ev0_val   = btlv_pkg::ERR_TOO_DEEP;
              end else begin
                ev_cnt    = 2'd1;
                ev0_kind  = (tag_r == btlv_pkg::TAG_SEQ) ? btlv_pkg::EV_SEQ
                                                         : btlv_pkg::EV_GET;
                ev0_val   = 32'(byte_r);
                push      = 1'b1;
                elem_nxt  = 8'd0;
                phase_nxt = PH_TAG;
              end
            end
            btlv_pkg::TAG_INT: begin
              // empty integer reads as zero
              if (byte_r == 8'd0) begin
                ev_cnt   = 2'd1;
                ev0_kind = btlv_pkg::EV_INT;
              end
            end
            btlv_pkg::TAG_STR: begin
              ev_cnt   = 2'd1;
              ev0_kind = btlv_pkg::EV_STR;
              ev0_val  = 32'(byte_r);
            end
            btlv_pkg::TAG_NULL: begin
              ev_cnt   = 2'd1;
              ev0_kind = btlv_pkg::EV_NULL;
              ev0_val  = 32'(byte_r);
            end
            btlv_pkg::TAG_OID: begin
              fsp_nxt = 1'b1;
              // empty OID gives two zero arcs
              if (byte_r == 8'd0) begin
                ev_cnt   = 2'd2;
                ev0_kind = btlv_pkg::EV_ARC;
                fsp_nxt  = 1'b0;
              end
            end
            default: begin
              ev_cnt   = 2'd1;
              ev0_kind = btlv_pkg::EV_UNK;
              ev0_val  = 32'(tag_r);
            end
          endcase
        end
      end
      PH_CONTENT: begin
        consume  = 1'b1;
        elem_nxt = elem_dec;
        unique case (tag_r)
          btlv_pkg::TAG_INT: begin
            acc_nxt = acc_int;
            if (elem_dec == 8'd0) begin
              ev_cnt   = 2'd1;
              ev0_kind = btlv_pkg::EV_INT;
              ev0_val  = acc_int;
            end
          end
          btlv_pkg::TAG_STR: begin
            ev_cnt   = 2'd1;
            ev0_kind = btlv_pkg::EV_BYTE;
            ev0_val  = 32'(byte_r);
          end
          btlv_pkg::TAG_OID: begin
            acc_nxt = acc_oid;
            // subidentifier ends on a clear bit 7 or at the end of content
            if (!byte_r[7] || (elem_dec == 8'd0)) begin
              acc_nxt = '0;
              if (fsp_r) begin
                ev_cnt   = 2'd2;
                ev0_kind = btlv_pkg::EV_ARC;
                ev0_val  = 32'(oid_q);
                ev1_val  = 32'(oid_r_full[5:0]);
                fsp_nxt  = 1'b0;
              end else begin
                ev_cnt   = 2'd1;
                ev0_kind = btlv_pkg::EV_ARC;
                ev0_val  = acc_oid;
              end
            end
          end
          default: begin
          end
        endcase
        if (elem_dec == 8'd0) begin
          phase_nxt = PH_TAG;
        end
      end
      PH_DISCARD: begin
      end
      default: begin
        phase_nxt = PH_DISCARD;
      end
    endcase
  end

  // Level stack commands, only on a decoded byte
  always_comb begin
    lvl_ctl_o.consume  = fire && consume;
    lvl_ctl_o.push     = fire && push;
    lvl_ctl_o.push_val = byte_r;
    lvl_ctl_o.close    = fire && (phase_nxt != PH_DISCARD);
    lvl_ctl_o.clear    = fire && eom_r;
  end

  // Events to the result queue
  always_comb begin
    evq_wr_o.cnt       = fire ? ev_cnt : 2'd0;
    evq_wr_o.ev0.kind  = ev0_kind;
    evq_wr_o.ev0.level = lvl;
    evq_wr_o.ev0.value = ev0_val;
    evq_wr_o.ev0.last  = (ev_cnt == 2'd1);
    evq_wr_o.ev1.kind  = ev1_kind;
    evq_wr_o.ev1.level = lvl;
    evq_wr_o.ev1.value = ev1_val;
    evq_wr_o.ev1.last  = 1'b1;
  end

  // State update; end of message returns everything to idle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      tag_r   <= 8'd0;
      elem_r  <= 8'd0;
      acc_r   <= '0;
      fsp_r   <= 1'b1;
    end else if (fire) begin
      if (eom_r) begin
        phase_r <= PH_TAG;
        tag_r   <= 8'd0;
        elem_r  <= 8'd0;
        acc_r   <= '0;
        fsp_r   <= 1'b1;
      end else begin
        phase_r <= phase_nxt;
        tag_r   <= tag_nxt;
        elem_r  <= elem_nxt;
        acc_r   <= acc_nxt;
        fsp_r   <= fsp_nxt;
      end
    end
  end

endmodule

FILE: design/btlv_evt_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btlv_evt_queue
// Small result queue: takes up to two events per cycle, hands out one per
// transfer. Decouples the decoder from stalls on the result side.
// ----------------------------------------------------------------------------
module btlv_evt_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  btlv_pkg::evq_wr_t  wr_i,
  output logic               room_o,
  btlv_out_if.source         out_ch
);

  localparam int AW = $clog2(btlv_pkg::EVQ_DEPTH);
  localparam int CW = $clog2(btlv_pkg::EVQ_DEPTH + 1);

  btlv_pkg::evt_t mem_r [btlv_pkg::EVQ_DEPTH];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW-1:0]  wp_inc;
  logic [CW-1:0]  cnt_r;
  logic           pop;
  btlv_pkg::evt_t head;

  assign pop    = out_ch.valid && out_ch.ready;
  assign wp_inc = wp_r + AW'(1);

  // Entry storage
  always_ff @(posedge clk) begin
    if (wr_i.cnt != 2'd0) begin
      mem_r[wp_r] <= wr_i.ev0;
    end
    if (wr_i.cnt == 2'd2) begin
      mem_r[wp_inc] <= wr_i.ev1;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(wr_i.cnt);
      rp_r  <= rp_r + AW'(pop);
      cnt_r <= cnt_r + CW'(wr_i.cnt) - CW'(pop);
    end
  end

  // Room for a two-event byte
  assign room_o = (cnt_r <= CW'(btlv_pkg::EVQ_DEPTH - 2));

  assign head               = mem_r[rp_r];
  assign out_ch.valid       = (cnt_r != '0);
  assign out_ch.event_kind  = head.kind;
  assign out_ch.nest_level  = head.level;
  assign out_ch.event_value = head.value;
  assign out_ch.last_of_run = head.last;

endmodule

FILE: bench/ber_tlv_stream_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_tlv_stream_decoder_tb
// Drives whole messages of BER TLV bytes into the decoder and checks every
// decode event against a cycle-free TLV walker kept inside the bench. Directed
// messages cover the field extremes and the error paths. Random traffic follows:
// mostly well-formed nested elements, plus corrupted, cut and noise messages.
// Both sides idle at random, and one long output stall fills the block.
// ----------------------------------------------------------------------------
module ber_tlv_stream_decoder_tb;

  localparam int DEPTH_LIMIT = 8;
  localparam int RANDOM_BYTES = 690;

  typedef logic [7:0] msg_t[$];
  typedef enum logic [1:0] {WALK_TAG, WALK_LEN, WALK_BODY, WALK_SKIP} walk_phase_t;

  logic clk;
  logic rst_n;

  btlv_in_if  in_ch();
  btlv_out_if out_ch();

  ber_tlv_stream_decoder #(.MAX_DEPTH(DEPTH_LIMIT)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  int             send_idle_pct  = 0;
  int             recv_stall_pct = 0;
  bit             recv_hold      = 1'b0;
  int             fail_count     = 0;
  int             sent_bytes     = 0;
  btlv_pkg::evt_t pending_events[$];

  // --------------------------------------------------------------------------
  // TLV walker: expected events per accepted byte
  // --------------------------------------------------------------------------
  walk_phase_t    walk_phase;
  logic [7:0]     walk_tag;
  logic [7:0]     lvl_left [DEPTH_LIMIT];
  int             walk_depth;
  logic [7:0]     elem_left;
  logic [31:0]    acc;
  logic           first_subid;
  btlv_pkg::evt_t step_events[$];

  function void walker_reset();
    walk_phase  = WALK_TAG;
    walk_tag    = '0;
    foreach (lvl_left[i]) lvl_left[i] = '0;
    walk_depth  = 0;
    elem_left   = '0;
    acc         = '0;
    first_subid = 1'b1;
  endfunction

  function void note_event(btlv_pkg::evt_kind_t kind, logic [31:0] value);
    btlv_pkg::evt_t ev;
    ev.kind  = kind;
    ev.level = walk_depth[3:0];
    ev.value = value;
    ev.last  = 1'b0;
    step_events.push_back(ev);
  endfunction

  // one byte read lowers every open container
  function void consume_byte();
    for (int i = 0; i < walk_depth; i++)
      if (lvl_left[i] > 0) lvl_left[i]--;
  endfunction

  function void flag_error(logic [31:0] code);
    walk_phase = WALK_SKIP;
    note_event(btlv_pkg::EV_ERR, code);
  endfunction

  // first subidentifier splits into two arcs
  function void oid_arc_out();
    if (first_subid) begin
      note_event(btlv_pkg::EV_ARC, acc / 40);
      note_event(btlv_pkg::EV_ARC, acc % 40);
      first_subid = 1'b0;
    end else begin
      note_event(btlv_pkg::EV_ARC, acc);
    end
    acc = '0;
  endfunction

  function void tlv_walk(logic [7:0] b, logic eom);
    bit in_box;
    step_events.delete();
    in_box = walk_depth > 0;
    case (walk_phase)
      WALK_TAG: begin
        if (in_box && lvl_left[walk_depth-1] <= 1) begin
          flag_error(btlv_pkg::ERR_OVERRUN);
        end else begin
          consume_byte();
          walk_tag   = b;
          walk_phase = WALK_LEN;
        end
      end
      WALK_LEN: begin
        consume_byte();
        if (in_box && b > lvl_left[walk_depth-1]) begin
          flag_error(btlv_pkg::ERR_OVERRUN);
        end else begin
          elem_left  = b;
          acc        = '0;
          walk_phase = (b == 0) ? WALK_TAG : WALK_BODY;
          case (walk_tag)
            btlv_pkg::TAG_SEQ, btlv_pkg::TAG_GET: begin
              if (walk_depth >= DEPTH_LIMIT) begin
                flag_error(btlv_pkg::ERR_TOO_DEEP);
              end else begin
                note_event((walk_tag == btlv_pkg::TAG_SEQ) ? btlv_pkg::EV_SEQ
                                                           : btlv_pkg::EV_GET,
                           {24'd0, b});
                lvl_left[walk_depth] = b;
                walk_depth++;
                elem_left  = '0;
                walk_phase = WALK_TAG;
              end
            end
            btlv_pkg::TAG_INT: if (b == 0) note_event(btlv_pkg::EV_INT, '0);
            btlv_pkg::TAG_STR: note_event(btlv_pkg::EV_STR, {24'd0, b});
            btlv_pkg::TAG_NULL: note_event(btlv_pkg::EV_NULL, {24'd0, b});
            btlv_pkg::TAG_OID: begin
              first_subid = 1'b1;
              if (b == 0) oid_arc_out();
            end
            default: note_event(btlv_pkg::EV_UNK, {24'd0, walk_tag});
          endcase
        end
      end
      WALK_BODY: begin
        consume_byte();
        if (elem_left > 0) elem_left--;
        case (walk_tag)
          btlv_pkg::TAG_INT: begin
            acc = {acc[23:0], b};
            if (elem_left == 0) note_event(btlv_pkg::EV_INT, acc);
          end
          btlv_pkg::TAG_STR: note_event(btlv_pkg::EV_BYTE, {24'd0, b});
          btlv_pkg::TAG_OID: begin
            acc = {acc[24:0], b[6:0]};
            if (!b[7] || elem_left == 0) oid_arc_out();
          end
          default: ;
        endcase
        if (elem_left == 0) walk_phase = WALK_TAG;
      end
      default: ;
    endcase

    // containers that ran out close silently
    if (walk_phase != WALK_SKIP)
      while (walk_depth > 0 && lvl_left[walk_depth-1] == 0) walk_depth--;

    if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
    foreach (step_events[i]) pending_events.push_back(step_events[i]);
    if (eom) walker_reset();
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task report_mismatch(input string what, input logic [31:0] got, input logic [31:0] want);
    fail_count++;
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  // outputs first, then the input transfer of the same edge
  always @(posedge clk) begin : check_events
    btlv_pkg::evt_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected event kind", out_ch.event_kind, '0);
      end else begin
        want = pending_events.pop_front();
        if (out_ch.event_kind !== want.kind)
          report_mismatch("event_kind", out_ch.event_kind, want.kind);
        if (out_ch.nest_level !== want.level)
          report_mismatch("nest_level", out_ch.nest_level, want.level);
        if (out_ch.event_value !== want.value)
          report_mismatch("event_value", out_ch.event_value, want.value);
        if (out_ch.last_of_run !== want.last)
          report_mismatch("last_of_run", out_ch.last_of_run, want.last);
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready)
      tlv_walk(in_ch.in_byte, in_ch.end_of_message);
  end

  // Result side: random stalls plus the long hold
  always @(negedge clk)
    out_ch.ready = !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // entered and left just after a falling edge
  task send_byte(input logic [7:0] b, input logic eom);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid          = 1'b1;
    in_ch.in_byte        = b;
    in_ch.end_of_message = eom;
    do @(posedge clk); while (!in_ch.ready);
    sent_bytes++;
    @(negedge clk);
  endtask

  task send_msg(input msg_t m);
    foreach (m[i]) send_byte(m[i], i == m.size() - 1);
    in_ch.valid = 1'b0;
  endtask

  task drain();
    while (pending_events.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function int min2(int a, int b);
    return (a < b) ? a : b;
  endfunction

  // one random well-formed element within budget bytes
  function automatic void gen_element(ref msg_t q, input int budget, input int lvl);
    int         cap;
    int         len;
    int         pick;
    int         inner;
    logic [7:0] tag;
    msg_t       body;
    if (budget < 2) return;
    cap  = min2(budget - 2, 255);
    pick = $urandom_range(0, (lvl < 9 && cap >= 2) ? 6 : 4);
    case (pick)
      0: begin tag = btlv_pkg::TAG_INT;  len = $urandom_range(0, min2(6, cap)); end
      1: begin tag = btlv_pkg::TAG_STR;  len = $urandom_range(0, min2(8, cap)); end
      2: begin
        tag = btlv_pkg::TAG_NULL;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, min2(2, cap)) : 0;
      end
      3: begin tag = btlv_pkg::TAG_OID;  len = $urandom_range(0, min2(7, cap)); end
      4: begin
        do tag = 8'($urandom_range(0, 255));
        while (tag inside {btlv_pkg::TAG_INT, btlv_pkg::TAG_STR, btlv_pkg::TAG_NULL,
                           btlv_pkg::TAG_OID, btlv_pkg::TAG_SEQ, btlv_pkg::TAG_GET});
        len = $urandom_range(0, min2(4, cap));
      end
      default: begin
        tag   = (pick == 5) ? btlv_pkg::TAG_SEQ : btlv_pkg::TAG_GET;
        inner = min2(cap, 30);
        while (body.size() + 2 <= inner && $urandom_range(0, 4) != 0)
          gen_element(body, inner - body.size(), lvl + 1);
        len = body.size();
      end
    endcase
    // OID bytes carry a continuation bit about a third of the time
    if (pick < 5)
      for (int i = 0; i < len; i++)
        body.push_back((pick == 3) ?
                       {($urandom_range(0, 2) == 0), 7'($urandom_range(0, 127))} :
                       8'($urandom_range(0, 255)));
    q.push_back(tag);
    q.push_back(8'(len));
    foreach (body[i]) q.push_back(body[i]);
  endfunction

  // integer wrapped in a chain of containers
  function automatic msg_t deep_chain(int levels);
    msg_t m;
    m = '{btlv_pkg::TAG_INT, 8'h01, 8'($urandom_range(0, 255))};
    repeat (levels) begin
      m.push_front(8'(m.size()));
      m.push_front($urandom_range(0, 1) ? btlv_pkg::TAG_SEQ : btlv_pkg::TAG_GET);
    end
    return m;
  endfunction

  // mostly well-formed, some corrupted, cut, noise or deep messages
  function automatic msg_t build_message();
    msg_t m;
    int   pick;
    int   pos;
    pick = $urandom_range(0, 19);
    if (pick == 0) begin
      m = deep_chain($urandom_range(6, 10));
    end else if (pick == 1) begin
      repeat ($urandom_range(1, 12)) m.push_back(8'($urandom_range(0, 255)));
    end else begin
      do gen_element(m, 40, 0);
      while (m.size() < 60 && $urandom_range(0, 2) != 0);
      if (pick == 2 || pick == 3) begin
        pos    = $urandom_range(0, m.size() - 1);
        m[pos] = 8'($urandom_range(0, 255));
      end else if (pick == 4) begin
        repeat ($urandom_range(1, m.size() - 1)) void'(m.pop_back());
      end
    end
    return m;
  endfunction

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // integer extremes and wrap, empty integer, string, null, unknown tag
  task test_scalars();
    send_msg('{btlv_pkg::TAG_INT, 8'h05, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h01,
               btlv_pkg::TAG_INT, 8'h00, btlv_pkg::TAG_STR, 8'h01, 8'h00,
               btlv_pkg::TAG_NULL, 8'h00, 8'hFF, 8'h00});
    drain();
  endtask

  // empty OID, large first subidentifier, OID cut short
  task test_oid();
    send_msg('{btlv_pkg::TAG_OID, 8'h00, btlv_pkg::TAG_OID, 8'h03, 8'h8F, 8'hFF, 8'h7F,
               btlv_pkg::TAG_OID, 8'h02, 8'h2B, 8'h81});
    drain();
  endtask

  // nesting, header cut short, child overrun, message end mid-element
  task test_containers();
    send_msg('{btlv_pkg::TAG_GET, 8'h04, btlv_pkg::TAG_SEQ, 8'h02,
               btlv_pkg::TAG_NULL, 8'h00});
    send_msg('{btlv_pkg::TAG_SEQ, 8'h01, btlv_pkg::TAG_INT});
    send_msg('{btlv_pkg::TAG_SEQ, 8'h02, btlv_pkg::TAG_STR, 8'h05, 8'h00});
    send_msg('{btlv_pkg::TAG_STR, 8'hFF, 8'h41});
    drain();
  endtask

  task test_too_deep();
    send_msg(deep_chain(DEPTH_LIMIT + 1));
    drain();
  endtask

  // long output hold while bytes keep coming
  task test_backpressure();
    msg_t m;
    repeat (6) begin
      m.push_back(btlv_pkg::TAG_STR);
      m.push_back(8'd12);
      repeat (12) m.push_back(8'($urandom_range(0, 255)));
    end
    fork
      begin
        recv_hold = 1'b1;
        repeat (300) @(posedge clk);
        recv_hold = 1'b0;
      end
    join_none
    send_msg(m);
    drain();
  endtask

  task test_random();
    int goal;
    goal = sent_bytes;
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 22 : (ph == 1) ? 88 : 0;
      recv_stall_pct = (ph == 0) ? 88 : (ph == 1) ? 22 : 0;
      goal += RANDOM_BYTES / 3;
      while (sent_bytes < goal) send_msg(build_message());
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.in_byte        = '0;
    in_ch.end_of_message = 1'b0;
    walker_reset();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_scalars();
    test_oid();
    test_containers();
    test_too_deep();
    test_backpressure();
    test_random();

    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending_events.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
